>>> src/bfbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbs_pkg
// Shared widths, constants and transaction types of the best-fit block
// suballocator.
// ----------------------------------------------------------------------------
package bfbs_pkg;

  localparam int REQ_W          = 24;  // request byte count
  localparam int SIZE_W         = 25;  // block capacity, used count, offset
  localparam int IDX_W          = 4;   // block index port width
  localparam int MAX_BLOCKS_DEF = 16;  // 1 .. 2**IDX_W
  localparam int PAGE_BITS      = 12;  // page of 4 KiB
  localparam int PAGE_BYTES     = 1 << PAGE_BITS;

  localparam logic [SIZE_W-1:0] DEFAULT_BLOCK_RST = SIZE_W'(65536);
  localparam logic [SIZE_W-1:0] PAGE_LOW_MASK     = SIZE_W'(PAGE_BYTES - 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } bfbs_state_t;

  // Search transaction that travels down the row of cells.
  typedef struct packed {
    logic              vld;
    logic [REQ_W-1:0]  req;
    logic              found;
    logic [IDX_W-1:0]  best_idx;
    logic [SIZE_W-1:0] best_free;
    logic [SIZE_W-1:0] best_used;
  } bfbs_pkt_t;

  // Update broadcast to all cells after a search completes.
  typedef struct packed {
    logic              en;
    logic              open;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] cap;
    logic [REQ_W-1:0]  req;
  } bfbs_wr_t;

  // Round a request up to a whole number of pages.
  function automatic logic [SIZE_W-1:0] bfbs_round_up(input logic [REQ_W-1:0] req);
    logic [SIZE_W-1:0] sum;
    sum = SIZE_W'(req) + PAGE_LOW_MASK;
    return sum & ~PAGE_LOW_MASK;
  endfunction

endpackage

>>> src/bfbs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbs_cell
// One block entry: holds capacity and bump pointer, refines the passing
// search transaction and forwards it to the next cell.
// ----------------------------------------------------------------------------
module bfbs_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bfbs_pkg::bfbs_pkt_t pkt_in,
  input  bfbs_pkg::bfbs_wr_t  wr,
  output bfbs_pkg::bfbs_pkt_t pkt_out
);
  import bfbs_pkg::*;

  logic              valid_r;
  logic [SIZE_W-1:0] cap_r;
  logic [SIZE_W-1:0] used_r;

  logic              pkt_vld_r;
  bfbs_pkt_t         pkt_r;
  bfbs_pkt_t         pkt_nxt;

  logic [SIZE_W-1:0] free_bytes;
  logic              fits;
  logic              wr_hit;

  assign free_bytes = cap_r - used_r;
  assign fits = valid_r && (free_bytes >= SIZE_W'(pkt_in.req)) &&
                (!pkt_in.found || (free_bytes < pkt_in.best_free));
  assign wr_hit = wr.en && (wr.idx == IDX_W'(CELL_IDX));

  always_comb begin
    pkt_nxt = pkt_in;
    if (fits) begin
      pkt_nxt.found     = 1'b1;
      pkt_nxt.best_idx  = IDX_W'(CELL_IDX);
      pkt_nxt.best_free = free_bytes;
      pkt_nxt.best_used = used_r;
    end
  end

  // Advance the search one cell per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_vld_r <= 1'b0;
    end else begin
      pkt_vld_r <= pkt_in.vld;
    end
    pkt_r <= pkt_nxt;
  end

  always_comb begin
    pkt_out     = pkt_r;
    pkt_out.vld = pkt_vld_r;
  end

  // Entry update: open a new block or bump the pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_hit && wr.open) begin
      valid_r <= 1'b1;
    end
    if (wr_hit) begin
      if (wr.open) begin
        cap_r  <= wr.cap;
        used_r <= SIZE_W'(wr.req);
      end else begin
        used_r <= used_r + SIZE_W'(wr.req);
      end
    end
  end

endmodule

>>> src/best_fit_block_suballocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_suballocator_core
// Best-fit placement of byte runs into a table of bump-allocated blocks.
// ----------------------------------------------------------------------------
// Pulse start with in_request_bytes while busy is low. The request travels
// down a row of MAX_BLOCKS block cells, one cell per cycle, picking the valid
// block with the least free space that still holds the request (lowest index
// on a tie). When it leaves the last cell the placement is committed, and the
// result appears in the next cycle on the out_ ports with out_valid high for
// exactly one cycle; the receiver cannot stall, so capture it on that cycle.
// busy stays high until the request leaves the last cell, and the next start
// is taken in the cycle out_valid is high, so a new request is taken only after
// the last one is through. If no block fits, a new one is opened in the next
// free slot with cfg_default_block_bytes, or with the request rounded up to 4
// KiB when larger; with all slots used, out_table_full is set and nothing is
// placed. Write cfg_default_block_bytes only while idle.
// ----------------------------------------------------------------------------
module best_fit_block_suballocator_core #(
  parameter int MAX_BLOCKS = bfbs_pkg::MAX_BLOCKS_DEF  // 1 .. 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [bfbs_pkg::SIZE_W-1:0] cfg_default_block_bytes,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic [bfbs_pkg::REQ_W-1:0]  in_request_bytes,
  // result
  output logic                        out_valid,
  output logic [bfbs_pkg::IDX_W-1:0]  out_block_index,
  output logic [bfbs_pkg::SIZE_W-1:0] out_byte_offset,
  output logic                        out_opened_new,
  output logic                        out_table_full
);
  import bfbs_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  bfbs_state_t       state_r;
  bfbs_state_t       state_nxt;

  logic [SIZE_W-1:0] default_bytes_r;
  logic [CNT_W-1:0]  opened_r;

  bfbs_pkt_t         chain [MAX_BLOCKS+1];
  bfbs_pkt_t         tail;
  bfbs_wr_t          wr;

  logic              accept;
  logic              table_is_full;
  logic [SIZE_W-1:0] new_cap;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_block_index_r;
  logic [SIZE_W-1:0] out_byte_offset_r;
  logic              out_opened_new_r;
  logic              out_table_full_r;

  assign accept = start && (state_r == ST_IDLE);
  assign tail   = chain[MAX_BLOCKS];

  // Inject a fresh search transaction at the head of the row.
  always_comb begin
    chain[0]           = '0;
    chain[0].vld       = accept;
    chain[0].req       = in_request_bytes;
  end

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    bfbs_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .pkt_in  (chain[g]),
      .wr      (wr),
      .pkt_out (chain[g+1])
    );
  end

  // Next state: scan until the transaction leaves the last cell.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.vld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Size of a block opened for this request.
  assign new_cap = (SIZE_W'(tail.req) > default_bytes_r) ? bfbs_round_up(tail.req)
                                                         : default_bytes_r;
  assign table_is_full = (opened_r == CNT_W'(MAX_BLOCKS));

  // Commit: bump the chosen block, or open the next slot.
  always_comb begin
    wr      = '0;
    wr.req  = tail.req;
    wr.cap  = new_cap;
    if (tail.vld) begin
      if (tail.found) begin
        wr.en  = 1'b1;
        wr.idx = tail.best_idx;
      end else if (!table_is_full) begin
        wr.en   = 1'b1;
        wr.open = 1'b1;
        wr.idx  = IDX_W'(opened_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      default_bytes_r <= DEFAULT_BLOCK_RST;
      opened_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= tail.vld;
      if (cfg_wr_en) begin
        default_bytes_r <= cfg_default_block_bytes;
      end
      if (wr.en && wr.open) begin
        opened_r <= opened_r + CNT_W'(1);
      end
    end
  end

  // Hold the result for its single strobe cycle.
  always_ff @(posedge clk) begin
    if (tail.vld) begin
      if (tail.found) begin
        out_block_index_r <= tail.best_idx;
        out_byte_offset_r <= tail.best_used;
        out_opened_new_r  <= 1'b0;
        out_table_full_r  <= 1'b0;
      end else if (table_is_full) begin
        out_block_index_r <= '0;
        out_byte_offset_r <= '0;
        out_opened_new_r  <= 1'b0;
        out_table_full_r  <= 1'b1;
      end else begin
        out_block_index_r <= IDX_W'(opened_r);
        out_byte_offset_r <= '0;
        out_opened_new_r  <= 1'b1;
        out_table_full_r  <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_block_index = out_block_index_r;
  assign out_byte_offset = out_byte_offset_r;
  assign out_opened_new  = out_opened_new_r;
  assign out_table_full  = out_table_full_r;

endmodule
